FILE: rtl/core/smc_pkg.sv
// ----------------------------------------------------------------------------
// smc_pkg
// Shared constants, codes and control structs of the same-mode convolver.
// ----------------------------------------------------------------------------
package smc_pkg;

    localparam int MAX_TAPS   = 64;
    localparam int TAP_W      = $clog2(MAX_TAPS);
    localparam int HIST_DEPTH = 2 ** TAP_W;
    localparam int FILL_W     = $clog2(MAX_TAPS + 1);
    localparam int CFG_W      = 7;
    localparam int DATA_W     = 16;
    localparam int IDX_W      = 6;
    localparam int PROD_W     = 2 * DATA_W;
    localparam int ACC_W      = 38;
    localparam int COUNT_W    = 7;
    localparam int COUNT_MAX  = 127;
    localparam int S_TDATA_W  = 24;
    localparam int M_TDATA_W  = 40;

    typedef enum logic {
        CMD_LOAD   = 1'b0,
        CMD_SAMPLE = 1'b1
    } cmd_t;

    typedef struct packed {
        logic load_kernel;
        logic push_sample;
        logic push_zero;
        logic issue;
        logic out_load;
        logic done_step;
    } ctrl_cmd_t;

    typedef struct packed {
        logic last_tap;
        logic pipe_busy;
        logic emit;
        logic out_free;
        logic flush_pending;
    } ctrl_sts_t;

endpackage

FILE: rtl/core/same_mode_convolver_unit.sv
// ----------------------------------------------------------------------------
// same_mode_convolver_unit
// Same-mode linear convolution of a 16-bit signal with a stored kernel.
//
//   channel  dir  handshake            payload
//   s_       in   s_tvalid/s_tready    s_tdata, s_tuser (command), s_tlast
//   m_       out  m_tvalid/m_tready    m_tdata (out_value), m_tlast
//   cfg_     in   cfg_wr_en            cfg_wr_data (kernel_length)
//
// A sample is processed by the single shared multiply-accumulate walking one
// tap per cycle through its L taps in use, then draining its read/multiply/add
// pipe; the last sample adds a zero flush of L / 2 pushed zeros. A stalled m_
// side holds the sequencer before it emits a term. Reset is synchronous,
// active low, and needs no clearing pass.
// ----------------------------------------------------------------------------
module same_mode_convolver_unit (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              cfg_wr_en,
    input  logic [smc_pkg::CFG_W-1:0]         cfg_wr_data,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // [15:0] sample_value, [21:16] tap_index, [23:22] zero
    input  logic [smc_pkg::S_TDATA_W-1:0]     s_tdata,
    // [0] command
    input  logic [0:0]                        s_tuser,
    input  logic                              s_tlast,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // [37:0] out_value, [39:38] zero
    output logic [smc_pkg::M_TDATA_W-1:0]     m_tdata,
    output logic                              m_tlast
);
    import smc_pkg::*;

    ctrl_cmd_t         cmd;
    ctrl_sts_t         sts;
    cmd_t              command;
    logic [ACC_W-1:0]  out_value;

    assign command = cmd_t'(s_tuser[0]);
    assign m_tdata = {{(M_TDATA_W - ACC_W){1'b0}}, out_value};

    smc_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .command  (command),
        .sts      (sts),
        .cmd      (cmd)
    );

    smc_datapath u_datapath (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_wr_data  (cfg_wr_data),
        .sample_value (s_tdata[DATA_W-1:0]),
        .tap_index    (s_tdata[DATA_W +: IDX_W]),
        .last_item    (s_tlast),
        .cmd          (cmd),
        .sts          (sts),
        .m_tvalid     (m_tvalid),
        .m_tready     (m_tready),
        .out_value    (out_value),
        .out_last     (m_tlast)
    );

endmodule

FILE: rtl/core/smc_ctrl.sv
// ----------------------------------------------------------------------------
// smc_ctrl
// Sequencer: accepts requests, walks the taps, drains the MAC pipe, emits
// terms and runs the zero flush after the last sample.
// ----------------------------------------------------------------------------
module smc_ctrl (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_tvalid,
    output logic               s_tready,
    input  smc_pkg::cmd_t      command,
    input  smc_pkg::ctrl_sts_t sts,
    output smc_pkg::ctrl_cmd_t cmd
);
    import smc_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE  = 3'b001,
        ST_MAC   = 3'b010,
        ST_DRAIN = 3'b100
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   accept;
    logic   step_end;

    assign s_tready = (state_reg == ST_IDLE);
    assign accept   = s_tvalid && s_tready;
    assign step_end = (state_reg == ST_DRAIN) && !sts.pipe_busy
                      && (!sts.emit || sts.out_free);

    always_comb begin
        state_next      = state_reg;
        cmd             = '0;
        cmd.load_kernel = accept && (command == CMD_LOAD);
        cmd.push_sample = accept && (command == CMD_SAMPLE);
        unique case (state_reg)
            ST_IDLE: begin
                if (cmd.push_sample) begin
                    state_next = ST_MAC;
                end
            end
            ST_MAC: begin
                cmd.issue = 1'b1;
                if (sts.last_tap) begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                if (step_end) begin
                    cmd.out_load = sts.emit;
                    if (sts.flush_pending) begin
                        cmd.push_zero = 1'b1;
                        state_next    = ST_MAC;
                    end else begin
                        cmd.done_step = 1'b1;
                        state_next    = ST_IDLE;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

`ifndef SYNTHESIS
    a_idle_pipe_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_IDLE) |-> !sts.pipe_busy)
        else $error("MAC pipe busy while idle");

    a_push_exclusive: assert property (@(posedge aclk) disable iff (!aresetn)
        !(cmd.push_sample && cmd.push_zero))
        else $error("sample and flush push together");

    a_mac_after_push: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.push_sample || cmd.push_zero) |=> (state_reg == ST_MAC))
        else $error("push not followed by tap walk");
`endif

endmodule

FILE: rtl/core/smc_datapath.sv
// ----------------------------------------------------------------------------
// smc_datapath
// Kernel and history memories, tap counter, one shared multiply-accumulate,
// sample bookkeeping and the output register.
// ----------------------------------------------------------------------------
module smc_datapath (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          cfg_wr_en,
    input  logic [smc_pkg::CFG_W-1:0]     cfg_wr_data,
    input  logic [smc_pkg::DATA_W-1:0]    sample_value,
    input  logic [smc_pkg::IDX_W-1:0]     tap_index,
    input  logic                          last_item,
    input  smc_pkg::ctrl_cmd_t            cmd,
    output smc_pkg::ctrl_sts_t            sts,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [smc_pkg::ACC_W-1:0]     out_value,
    output logic                          out_last
);
    import smc_pkg::*;

    logic [CFG_W-1:0]         klen_reg;
    logic [FILL_W-1:0]        taps;
    logic [TAP_W-1:0]         half;

    logic signed [DATA_W-1:0] kmem [MAX_TAPS];
    logic signed [DATA_W-1:0] hmem [HIST_DEPTH];

    logic [TAP_W-1:0]         wr_ptr_reg;
    logic [TAP_W-1:0]         tap_reg;
    logic [TAP_W-1:0]         hist_addr;
    logic [FILL_W-1:0]        fill_reg;
    logic [COUNT_W-1:0]       count_reg;
    logic [TAP_W-1:0]         flush_left_reg;
    logic                     last_reg;
    logic                     emit_reg;
    logic                     push;

    logic signed [DATA_W-1:0] kd_reg;
    logic signed [DATA_W-1:0] hd_reg;
    logic                     hvalid_reg;
    logic                     v1_reg;
    logic                     v2_reg;
    logic signed [PROD_W-1:0] prod_reg;
    logic signed [ACC_W-1:0]  acc_reg;

    logic                     m_valid_reg;
    logic [ACC_W-1:0]         m_data_reg;
    logic                     m_last_reg;

    always_comb begin
        if (klen_reg == '0) begin
            taps = FILL_W'(1);
        end else if (int'(klen_reg) > MAX_TAPS) begin
            taps = FILL_W'(MAX_TAPS);
        end else begin
            taps = FILL_W'(klen_reg);
        end
        half = TAP_W'(taps >> 1);
    end

    assign push      = cmd.push_sample || cmd.push_zero;
    assign hist_addr = wr_ptr_reg - TAP_W'(1) - tap_reg;

    assign sts.last_tap      = (tap_reg == TAP_W'(taps - FILL_W'(1)));
    assign sts.pipe_busy     = v1_reg || v2_reg;
    assign sts.emit          = emit_reg;
    assign sts.out_free      = !m_valid_reg || m_tready;
    assign sts.flush_pending = (flush_left_reg != '0);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            klen_reg <= CFG_W'(1);
        end else if (cfg_wr_en) begin
            klen_reg <= cfg_wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load_kernel && (int'(tap_index) < MAX_TAPS)) begin
            kmem[TAP_W'(tap_index)] <= sample_value;
        end
        kd_reg <= kmem[tap_reg];
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            hmem[wr_ptr_reg] <= cmd.push_sample ? sample_value : '0;
        end
        hd_reg <= hmem[hist_addr];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg     <= '0;
            tap_reg        <= '0;
            fill_reg       <= '0;
            count_reg      <= '0;
            flush_left_reg <= '0;
            last_reg       <= 1'b0;
            emit_reg       <= 1'b0;
            v1_reg         <= 1'b0;
            v2_reg         <= 1'b0;
        end else begin
            v1_reg <= cmd.issue;
            v2_reg <= v1_reg;
            if (push) begin
                wr_ptr_reg <= wr_ptr_reg + TAP_W'(1);
                tap_reg    <= '0;
                emit_reg   <= (count_reg >= COUNT_W'(half));
                if (int'(fill_reg) < MAX_TAPS) begin
                    fill_reg <= fill_reg + FILL_W'(1);
                end
                if (int'(count_reg) < COUNT_MAX) begin
                    count_reg <= count_reg + COUNT_W'(1);
                end
            end else if (cmd.issue) begin
                tap_reg <= tap_reg + TAP_W'(1);
            end
            if (cmd.push_sample) begin
                last_reg       <= last_item;
                flush_left_reg <= last_item ? half : '0;
            end else if (cmd.push_zero) begin
                flush_left_reg <= flush_left_reg - TAP_W'(1);
            end
            if (cmd.done_step && last_reg) begin
                fill_reg  <= '0;
                count_reg <= '0;
                last_reg  <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        hvalid_reg <= (FILL_W'(tap_reg) < fill_reg);
        prod_reg   <= kd_reg * (hvalid_reg ? hd_reg : DATA_W'(0));
        if (push) begin
            acc_reg <= '0;
        end else if (v2_reg) begin
            acc_reg <= acc_reg + ACC_W'(prod_reg);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.out_load) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.out_load) begin
            m_data_reg <= acc_reg;
            m_last_reg <= last_reg && (flush_left_reg == '0);
        end
    end

    assign m_tvalid  = m_valid_reg;
    assign out_value = m_data_reg;
    assign out_last  = m_last_reg;

`ifndef SYNTHESIS
    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.out_load |-> (!m_valid_reg || m_tready))
        else $error("output term overwritten while stalled");

    a_flush_needs_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (flush_left_reg != '0) |-> last_reg)
        else $error("flush pending without last sample");

    a_fill_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        int'(fill_reg) <= MAX_TAPS)
        else $error("history fill beyond tap count");
`endif

endmodule

FILE: sim/tb_same_mode_convolver_unit.sv
// ----------------------------------------------------------------------------
// tb_same_mode_convolver_unit
// Self-checking bench for the same-mode convolver. A scoreboard predicts every
// output term from the accepted requests, the stored kernel and the current
// kernel length. Directed requests cover field extremes, single-sample and
// short signals and a length change inside a signal. Random signals then run
// under several kernel lengths and idle patterns, including a long output
// hold-off that backs up the input.
// ----------------------------------------------------------------------------
module tb_same_mode_convolver_unit;

    import smc_pkg::*;

    localparam int HOLD_OFF_CYCLES = 400;
    localparam int DRAIN_CYCLES    = 150;
    localparam int PHASE_BUDGET    = 14;

    typedef struct {
        logic signed [ACC_W-1:0] value;
        bit                      last;
    } conv_term_t;

    class conv_scoreboard;
        logic signed [DATA_W-1:0] coeff   [MAX_TAPS];
        logic signed [DATA_W-1:0] history [MAX_TAPS];
        int unsigned              seen;
        logic [CFG_W-1:0]         length_reg;
        conv_term_t               expected_terms [$];
        int                       errors;
        int                       terms_checked;

        function new();
            foreach (coeff[i]) coeff[i] = '0;
            foreach (history[i]) history[i] = '0;
            seen          = 0;
            length_reg    = 1;
            errors        = 0;
            terms_checked = 0;
        endfunction

        function int unsigned active_taps();
            if (length_reg == 0) return 1;
            if (length_reg > MAX_TAPS) return MAX_TAPS;
            return length_reg;
        endfunction

        function void shift_in(logic signed [DATA_W-1:0] v);
            for (int i = MAX_TAPS - 1; i > 0; i--) history[i] = history[i-1];
            history[0] = v;
        endfunction

        function logic signed [ACC_W-1:0] conv_term(int unsigned taps);
            longint acc;
            acc = 0;
            for (int unsigned j = 0; j < taps; j++)
                acc += longint'(coeff[j]) * longint'(history[j]);
            return acc[ACC_W-1:0];
        endfunction

        function void note_config(logic [CFG_W-1:0] v);
            length_reg = v;
        endfunction

        function void note_request(cmd_t cmd, logic signed [DATA_W-1:0] value,
                                   logic [IDX_W-1:0] tap, bit last);
            int unsigned taps;
            int unsigned half;
            int          n;
            conv_term_t  t;
            if (cmd == CMD_LOAD) begin
                coeff[tap] = value;
                return;
            end
            taps = active_taps();
            half = taps / 2;
            n    = 0;
            shift_in(value);
            if (seen >= half) begin
                t.value = conv_term(taps);
                t.last  = 1'b0;
                expected_terms.push_back(t);
                n++;
            end
            if (seen < COUNT_MAX) seen++;
            if (last) begin
                for (int unsigned k = 0; k < half; k++) begin
                    shift_in('0);
                    if (seen + k >= half) begin
                        t.value = conv_term(taps);
                        t.last  = 1'b0;
                        expected_terms.push_back(t);
                        n++;
                    end
                end
                if (n > 0) expected_terms[expected_terms.size()-1].last = 1'b1;
                foreach (history[i]) history[i] = '0;
                seen = 0;
            end
        endfunction

        function void check_term(logic [M_TDATA_W-1:0] data, logic last);
            conv_term_t t;
            if (expected_terms.size() == 0) begin
                $error("unexpected term: out_value %0d, out_last %0b",
                       $signed(data[ACC_W-1:0]), last);
                errors++;
                return;
            end
            t = expected_terms.pop_front();
            terms_checked++;
            if (data[ACC_W-1:0] !== t.value) begin
                $error("out_value mismatch: expected %0d, actual %0d",
                       t.value, $signed(data[ACC_W-1:0]));
                errors++;
            end
            if (last !== t.last) begin
                $error("out_last mismatch: expected %0b, actual %0b", t.last, last);
                errors++;
            end
        endfunction
    endclass

    logic                   aclk;
    logic                   aresetn;
    logic                   cfg_wr_en;
    logic [CFG_W-1:0]       cfg_wr_data;
    logic                   s_tvalid;
    logic                   s_tready;
    logic [S_TDATA_W-1:0]   s_tdata;
    logic [0:0]             s_tuser;
    logic                   s_tlast;
    logic                   m_tvalid;
    logic                   m_tready;
    logic [M_TDATA_W-1:0]   m_tdata;
    logic                   m_tlast;

    conv_scoreboard conv_check = new();
    bit             tap_written [MAX_TAPS];
    int             send_idle_pct;
    int             recv_idle_pct;
    bit             hold_off_armed;
    int             n_samples;
    int             n_loads;
    int             n_settings;

    same_mode_convolver_unit uut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .s_tlast     (s_tlast),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tlast     (m_tlast)
    );

    initial begin
        aclk = 1'b0;
        forever #4 aclk = ~aclk;
    end

    initial begin
        #40_000_000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    initial begin
        m_tready <= 1'b0;
        forever begin
            @(posedge aclk);
            if (aresetn && m_tvalid && m_tready) conv_check.check_term(m_tdata, m_tlast);
            if (hold_off_armed) begin
                hold_off_armed = 1'b0;
                m_tready <= 1'b0;
                repeat (HOLD_OFF_CYCLES) @(posedge aclk);
            end else begin
                m_tready <= ($urandom_range(99) >= recv_idle_pct);
            end
        end
    end

    function automatic logic [DATA_W-1:0] rand_value();
        case ($urandom_range(15))
            0:       return 16'h8000;
            1:       return 16'h7FFF;
            2:       return 16'h0000;
            default: return DATA_W'($urandom);
        endcase
    endfunction

    task automatic send_request(cmd_t cmd, logic [DATA_W-1:0] value,
                                logic [IDX_W-1:0] tap, bit last);
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {2'b00, tap, value};
        s_tuser  <= cmd;
        s_tlast  <= last;
        do @(posedge aclk); while (!s_tready);
        conv_check.note_request(cmd, value, tap, last);
        if (cmd == CMD_LOAD) begin
            tap_written[tap] = 1'b1;
            n_loads++;
        end else begin
            n_samples++;
        end
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        while (conv_check.expected_terms.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task automatic set_length(logic [CFG_W-1:0] len);
        drain();
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= len;
        @(posedge aclk);
        conv_check.note_config(len);
        cfg_wr_en <= 1'b0;
        n_settings++;
    endtask

    task automatic run_signals(int budget);
        int sent;
        int sig_len;
        sent = 0;
        while (sent < budget) begin
            sig_len = ($urandom_range(9) == 0) ? $urandom_range(40, 12) : $urandom_range(6, 1);
            for (int i = 0; i < sig_len; i++) begin
                if ($urandom_range(11) == 0) begin
                    send_request(CMD_LOAD, rand_value(), IDX_W'($urandom),
                                 1'($urandom_range(1)));
                    sent++;
                end
                send_request(CMD_SAMPLE, rand_value(), IDX_W'($urandom), i == sig_len - 1);
                sent++;
            end
        end
    endtask

    task automatic run_phase(logic [CFG_W-1:0] len, int budget);
        set_length(len);
        for (int t = 0; t < conv_check.active_taps(); t++)
            if (!tap_written[t])
                send_request(CMD_LOAD, rand_value(), IDX_W'(t), 1'($urandom_range(1)));
        run_signals(budget);
    endtask

    initial begin
        aresetn        <= 1'b0;
        cfg_wr_en      <= 1'b0;
        cfg_wr_data    <= '0;
        s_tvalid       <= 1'b0;
        s_tdata        <= '0;
        s_tuser        <= CMD_LOAD;
        s_tlast        <= 1'b0;
        hold_off_armed  = 1'b0;
        n_samples       = 0;
        n_loads         = 0;
        n_settings      = 0;
        send_idle_pct   = 26;
        recv_idle_pct   = 74;
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        send_request(CMD_LOAD, 16'h8000, 0, 1'b1);
        send_request(CMD_LOAD, 16'h7FFF, 63, 1'b0);
        send_request(CMD_SAMPLE, 16'h7FFF, 6'h3F, 1'b0);
        send_request(CMD_SAMPLE, 16'h0000, 6'h00, 1'b0);
        send_request(CMD_SAMPLE, 16'h8000, 6'h15, 1'b1);
        set_length(0);
        send_request(CMD_SAMPLE, 16'hFFFF, 6'h2A, 1'b1);
        send_request(CMD_LOAD, 16'h7FFF, 1, 1'b0);
        send_request(CMD_LOAD, 16'h8000, 2, 1'b0);
        send_request(CMD_LOAD, 16'h0001, 3, 1'b1);
        send_request(CMD_LOAD, 16'hFFFF, 4, 1'b0);
        send_request(CMD_LOAD, 16'hFFFE, 5, 1'b0);
        set_length(6);
        send_request(CMD_SAMPLE, 16'h7FFF, 6'h00, 1'b1);
        send_request(CMD_SAMPLE, 16'h8000, 6'h3F, 1'b0);
        send_request(CMD_SAMPLE, 16'h8000, 6'h00, 1'b1);
        send_request(CMD_SAMPLE, 16'h0064, 6'h00, 1'b0);
        send_request(CMD_SAMPLE, 16'hFF38, 6'h00, 1'b0);
        set_length(2);
        send_request(CMD_SAMPLE, 16'h7FFF, 6'h00, 1'b0);
        send_request(CMD_SAMPLE, 16'h0005, 6'h00, 1'b1);

        run_phase(127, PHASE_BUDGET);
        run_phase(5, PHASE_BUDGET);
        run_phase(64, PHASE_BUDGET);

        send_idle_pct = 74;
        recv_idle_pct = 26;
        run_phase(33, PHASE_BUDGET);
        run_phase(0, PHASE_BUDGET);
        run_phase(12, PHASE_BUDGET);
        run_phase(64, PHASE_BUDGET);

        send_idle_pct = 0;
        recv_idle_pct = 0;
        set_length(1);
        hold_off_armed = 1'b1;
        run_signals(PHASE_BUDGET);
        set_length(3);
        for (int i = 0; i < 128; i++)
            send_request(CMD_SAMPLE, rand_value(), IDX_W'($urandom), i == 127);
        run_phase(64, PHASE_BUDGET);
        run_phase(CFG_W'($urandom_range(127)), PHASE_BUDGET);

        drain();
        $display("Run covered %0d samples and %0d kernel loads over %0d length settings,",
                 n_samples, n_loads, n_settings);
        $display("checking %0d output terms against the prediction.",
                 conv_check.terms_checked);
        if (conv_check.errors == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
